// ----- hdl/ncmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Nibble command memory port package
// Opcode and sub-code constants shared by the command interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package ncmp_pkg;

  typedef logic [3:0] nibble_t;

  localparam nibble_t OP_ADDR_HI  = 4'h1;
  localparam nibble_t OP_ROUTINE  = 4'h2;
  localparam nibble_t OP_HOLD     = 4'h3;
  localparam nibble_t OP_ADDR_LO  = 4'h4;
  localparam nibble_t OP_PAGE     = 4'h5;
  localparam nibble_t OP_WRITE    = 4'h6;
  localparam nibble_t OP_READ     = 4'h7;
  localparam nibble_t OP_LOCK     = 4'h8;

  localparam nibble_t SUB_READ    = 4'h1;
  localparam nibble_t LOCK_MAX    = 4'h3;

endpackage

`default_nettype wire

// ----- hdl/nibble_command_memory_port.sv -----
// ----------------------------------------------------------------------------
// Nibble command memory port
// Interprets single command bytes that set address, page, holding nibble and
// lock level, write and read a paged byte memory and request routines.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item moves through registers s1 and then s2 to the outputs.
// Throughput: one item per cycle while in_stall is low; the memory has one read and one write port.
// Reset: the control registers clear at once, then a sweep zeroes the memory one
// byte per cycle over all PAGE_COUNT * 2**ADDR_BITS bytes (16384 at the defaults),
// during which in_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_command_memory_port
  import ncmp_pkg::*;
#(
  parameter int PAGE_COUNT = 4,
  parameter int ADDR_BITS  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_command_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_read_valid,
  output logic [7:0]       out_read_data,
  output logic             out_routine_start,
  output logic [3:0]       out_routine_number,
  output logic [1:0]       out_lock_level_now,
  output logic [3:0]       out_page_now,
  output logic [11:0]      out_address_now,
  output logic             out_unknown_command
);

  localparam int MEM_DEPTH = PAGE_COUNT << ADDR_BITS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  logic [7:0]            mem [MEM_DEPTH];
  logic [7:0]            mem_q_r;

  logic                  clearing_r;
  logic [MEM_AW-1:0]     clr_idx_r;

  logic [3:0]            page_r, page_nxt;
  logic [ADDR_BITS-1:0]  addr_r, addr_nxt;
  logic [3:0]            hold_r, hold_nxt;
  logic [1:0]            lock_r, lock_nxt;

  logic                  s1_valid_r;
  logic                  s1_rd_valid_r, s1_rd_ok_r, s1_rt_start_r, s1_unknown_r;
  logic [3:0]            s1_rt_num_r, s1_page_r;
  logic [1:0]            s1_lock_r;
  logic [ADDR_BITS-1:0]  s1_addr_r;

  logic                  s2_valid_r;
  logic                  s2_rd_valid_r, s2_rt_start_r, s2_unknown_r;
  logic [7:0]            s2_data_r;
  logic [3:0]            s2_rt_num_r, s2_page_r;
  logic [1:0]            s2_lock_r;
  logic [ADDR_BITS-1:0]  s2_addr_r;

  logic                  accept, s1_adv, s2_free;
  logic [3:0]            op, x;
  logic [11:0]           addr_wide;
  logic                  page_ok;
  logic [MEM_AW-1:0]     mem_idx;
  logic                  rd_en, wr_en, rd_valid, rt_start, unknown;

  assign s2_free  = !s2_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = clearing_r || (s1_valid_r && !s2_free);
  assign accept   = in_valid && !in_stall;

  assign op        = in_command_byte[7:4];
  assign x         = in_command_byte[3:0];
  assign addr_wide = 12'(addr_r);
  assign page_ok   = 32'(page_r) < PAGE_COUNT;
  assign mem_idx   = MEM_AW'({page_r, addr_r});

  always_comb begin
    page_nxt = page_r;
    addr_nxt = addr_r;
    hold_nxt = hold_r;
    lock_nxt = lock_r;
    rd_valid = 1'b0;
    rt_start = 1'b0;
    unknown  = 1'b0;
    wr_en    = 1'b0;
    case (op)
      OP_ADDR_HI: begin
        addr_nxt = ADDR_BITS'({x, addr_wide[7:0]});
      end
      OP_ROUTINE: begin
        rt_start = 1'b1;
      end
      OP_HOLD: begin
        hold_nxt = x;
      end
      OP_ADDR_LO: begin
        addr_nxt = ADDR_BITS'({hold_r, x});
      end
      OP_PAGE: begin
        page_nxt = x;
      end
      OP_WRITE: begin
        wr_en    = page_ok;
        addr_nxt = addr_r + ADDR_BITS'(1);
        hold_nxt = 4'h0;
      end
      OP_READ: begin
        if (x == SUB_READ) begin
          rd_valid = 1'b1;
          addr_nxt = addr_r + ADDR_BITS'(1);
        end else begin
          unknown = 1'b1;
        end
      end
      OP_LOCK: begin
        if (x <= LOCK_MAX) begin
          lock_nxt = x[1:0];
        end else begin
          unknown = 1'b1;
        end
      end
      default: begin
        unknown = 1'b1;
      end
    endcase
  end

  assign rd_en = accept && rd_valid && page_ok;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= 8'h00;
    end else if (accept && wr_en) begin
      mem[mem_idx] <= {hold_r, x};
    end
    if (rd_en) begin
      mem_q_r <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      page_r     <= '0;
      addr_r     <= '0;
      hold_r     <= '0;
      lock_r     <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + MEM_AW'(1);
        if (clr_idx_r == MEM_AW'(MEM_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        page_r <= page_nxt;
        addr_r <= addr_nxt;
        hold_r <= hold_nxt;
        lock_r <= lock_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (!out_stall) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_valid_r <= rd_valid;
      s1_rd_ok_r    <= rd_valid && page_ok;
      s1_rt_start_r <= rt_start;
      s1_rt_num_r   <= rt_start ? x : 4'h0;
      s1_unknown_r  <= unknown;
      s1_lock_r     <= lock_nxt;
      s1_page_r     <= page_nxt;
      s1_addr_r     <= addr_nxt;
    end
    if (s1_adv) begin
      s2_rd_valid_r <= s1_rd_valid_r;
      s2_data_r     <= s1_rd_ok_r ? mem_q_r : 8'h00;
      s2_rt_start_r <= s1_rt_start_r;
      s2_rt_num_r   <= s1_rt_num_r;
      s2_unknown_r  <= s1_unknown_r;
      s2_lock_r     <= s1_lock_r;
      s2_page_r     <= s1_page_r;
      s2_addr_r     <= s1_addr_r;
    end
  end

  assign out_valid           = s2_valid_r;
  assign out_read_valid      = s2_rd_valid_r;
  assign out_read_data       = s2_data_r;
  assign out_routine_start   = s2_rt_start_r;
  assign out_routine_number  = s2_rt_num_r;
  assign out_lock_level_now  = s2_lock_r;
  assign out_page_now        = s2_page_r;
  assign out_address_now     = 12'(s2_addr_r);
  assign out_unknown_command = s2_unknown_r;

endmodule

`default_nettype wire
